@@ hw/rtl/tkst_pkg.sv @@
`timescale 1ns / 1ps

package tkst_pkg;

   // Item kinds carried on the request tuser bit.
   typedef enum logic {
      OP_OFFER = 1'b0,
      OP_READ  = 1'b1
   } tkst_op_type;

   // Widths of the fixed record fields.
   localparam int SCORE_W      = 16;
   localparam int BYTE_W       = 8;
   localparam int SLOT_W       = 3;
   localparam int SLOT_RANGE   = 8;
   localparam int IN_LETTERS   = 3;
   localparam int MAX_LETTERS  = 8;
   // Score, player and mode sit below the initials in a record.
   localparam int LETTER_BASE  = SCORE_W + 2 * BYTE_W;

   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_Z     = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   // Command broadcast from the front end to every cell of the row.
   typedef struct packed {
      logic              offer;
      logic              read;
      logic [SLOT_W-1:0] read_index;
   } tkst_cmd_type;

   // An initial outside A to Z is stored as a space.
   function automatic logic [BYTE_W-1:0] clean_letter(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      if ((c < CHAR_A) || (c > CHAR_Z)) begin
         r = CHAR_SPACE;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/tkst_cell.sv @@
`timescale 1ns / 1ps

module tkst_cell #(
   parameter int REC_W   = 56,
   parameter int CELL_ID = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tkst_pkg::tkst_cmd_type cmd,
   input  logic [REC_W-1:0]      new_rec,
   input  logic                  prev_gt,
   input  logic [REC_W-1:0]      prev_rec,
   output logic                  gt,
   output logic [REC_W-1:0]      rec,
   output logic                  hit,
   output logic [tkst_pkg::SLOT_W-1:0] hit_slot,
   output logic [REC_W-1:0]      read_rec
);
   import tkst_pkg::*;

   localparam logic [SLOT_W-1:0] SLOT_CODE = SLOT_W'(CELL_ID);
   localparam bit                READABLE  = (CELL_ID < SLOT_RANGE);

   logic [REC_W-1:0] rec_ff;
   logic [REC_W-1:0] rec_in;
   logic             shift;
   logic             insert;

   // The offer beats this record; the row is sorted, so this holds for all later cells too.
   assign gt     = new_rec[SCORE_W-1:0] > rec_ff[SCORE_W-1:0];
   assign shift  = cmd.offer && prev_gt;
   assign insert = cmd.offer && gt && !prev_gt;

   // Take the left neighbor's record on a shift, the offer at the insert point.
   always_comb begin
      rec_in = rec_ff;
      if (shift) begin
         rec_in = prev_rec;
      end else if (insert) begin
         rec_in = new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec      = rec_ff;
   assign hit      = insert;
   assign hit_slot = insert ? SLOT_CODE : '0;

   // Drive the stored record onto the read bus only when this slot is addressed.
   always_comb begin
      read_rec = '0;
      if (READABLE && cmd.read && (cmd.read_index == SLOT_CODE)) begin
         read_rec = rec_ff;
      end
   end

endmodule

@@ hw/rtl/top_k_sorted_insert_table.sv @@
`timescale 1ns / 1ps

// Channel  Dir  tdata                                    tuser
// req_     in   score, player, mode, 3 initials, index  op (0 offer, 1 read)
// rsp_     out  slot, score, player, mode, 3 initials    accepted
//
// One request beat is taken per cycle while the response side keeps up; the row
// of cells compares the offered score against every stored record at once and
// shifts in that same cycle. The response is registered and appears in the
// cycle after the request beat. A stalled response holds the request side only
// until it is taken; a new request is accepted in the cycle the waiting response
// leaves. Synchronous reset clears every record to zero.

module top_k_sorted_insert_table #(
   parameter int ENTRIES = 8,
   parameter int LETTERS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // score[15:0], player[23:16], mode[31:24], letter_first[39:32],
   // letter_second[47:40], letter_third[55:48], read_index[58:56], zero fill
   input  logic [63:0] req_tdata,
   // op[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot[2:0], entry_score[18:3], entry_player[26:19], entry_mode[34:27],
   // entry_letter_first[42:35], entry_letter_second[50:43],
   // entry_letter_third[58:51], zero fill
   output logic [63:0] rsp_tdata,
   // accepted[0]
   output logic [0:0]  rsp_tuser
);
   import tkst_pkg::*;

   localparam int REC_W     = LETTER_BASE + BYTE_W * LETTERS;
   localparam int PAD_LET   = (LETTERS > IN_LETTERS) ? LETTERS : IN_LETTERS;
   localparam int REC_PAD_W = LETTER_BASE + BYTE_W * PAD_LET;
   localparam int RSP_W     = SLOT_W + LETTER_BASE + BYTE_W * IN_LETTERS;

   tkst_cmd_type              cmd;
   logic                      req_accept;
   tkst_op_type               op;
   logic [REC_W-1:0]          new_rec;
   logic [BYTE_W*MAX_LETTERS-1:0] letters_pad;

   logic [REC_W-1:0]          rec_q    [ENTRIES];
   logic [REC_W-1:0]          read_q   [ENTRIES];
   logic [ENTRIES-1:0]        gt_q;
   logic [ENTRIES-1:0]        hit_q;
   logic [SLOT_W-1:0]         slot_q   [ENTRIES];

   logic [REC_W-1:0]          read_or;
   logic [SLOT_W-1:0]         slot_or;
   logic [REC_PAD_W-1:0]      read_pad;
   logic [RSP_W-1:0]          rsp_word;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [63:0]               rsp_data_ff;
   logic [0:0]                rsp_user_ff;

   // Request side is open whenever the response register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign op         = tkst_op_type'(req_tuser[0]);

   assign cmd.offer      = req_accept && (op == OP_OFFER);
   assign cmd.read       = req_accept && (op == OP_READ);
   assign cmd.read_index = req_tdata[58:56];

   // Build the offered record; initials past the third are stored as zero.
   always_comb begin
      letters_pad = '0;
      for (int k = 0; k < IN_LETTERS; k++) begin
         letters_pad[BYTE_W*k +: BYTE_W] = clean_letter(req_tdata[32 + BYTE_W*k +: BYTE_W]);
      end
      new_rec = '0;
      new_rec[LETTER_BASE-1:0] = req_tdata[LETTER_BASE-1:0];
      for (int k = 0; k < LETTERS; k++) begin
         new_rec[LETTER_BASE + BYTE_W*k +: BYTE_W] = letters_pad[BYTE_W*k +: BYTE_W];
      end
   end

   // Row of cells, best record in cell 0.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic             prev_gt;
      logic [REC_W-1:0] prev_rec;
      if (i == 0) begin : g_head
         assign prev_gt  = 1'b0;
         assign prev_rec = '0;
      end else begin : g_link
         assign prev_gt  = gt_q[i-1];
         assign prev_rec = rec_q[i-1];
      end
      tkst_cell #(
         .REC_W   (REC_W),
         .CELL_ID (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .new_rec  (new_rec),
         .prev_gt  (prev_gt),
         .prev_rec (prev_rec),
         .gt       (gt_q[i]),
         .rec      (rec_q[i]),
         .hit      (hit_q[i]),
         .hit_slot (slot_q[i]),
         .read_rec (read_q[i])
      );
   end

   // At most one cell reports an insert and one a read, so the buses are OR-merged.
   always_comb begin
      read_or = '0;
      slot_or = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         read_or = read_or | read_q[i];
         slot_or = slot_or | slot_q[i];
      end
   end

   assign read_pad = REC_PAD_W'(read_or);

   // Response word: reads report the index and the stored record, offers the insert slot with zero fields.
   always_comb begin
      rsp_word = '0;
      if (op == OP_READ) begin
         rsp_word[SLOT_W-1:0] = cmd.read_index;
         rsp_word[SLOT_W +: LETTER_BASE] = read_pad[LETTER_BASE-1:0];
         for (int k = 0; k < IN_LETTERS; k++) begin
            rsp_word[SLOT_W + LETTER_BASE + BYTE_W*k +: BYTE_W] =
               read_pad[LETTER_BASE + BYTE_W*k +: BYTE_W];
         end
      end else begin
         rsp_word[SLOT_W-1:0] = slot_or;
      end
   end

   // Output register.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= 64'(rsp_word);
         rsp_user_ff <= (op == OP_OFFER) ? |hit_q : 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The table stays sorted by descending score.
   for (genvar i = 0; i + 1 < ENTRIES; i++) begin : g_chk_sorted
      assert property (@(posedge clock) disable iff (reset)
         rec_q[i][SCORE_W-1:0] >= rec_q[i+1][SCORE_W-1:0])
         else $error("table order broken between neighboring cells");
   end

   // An offer lands in at most one cell.
   assert property (@(posedge clock) disable iff (reset) $onehot0(hit_q))
      else $error("offer inserted in more than one cell");

   // An accepted offer reports zero record fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[58:SLOT_W] == '0))
      else $error("accepted offer carries record data");

   // After reset the best record is empty.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (rec_q[0] == '0))
      else $error("head cell not cleared by reset");

endmodule

@@ tb/top_k_table_checker.sv @@
`timescale 1ns / 1ps

module top_k_table_checker #(
   parameter int ENTRIES = 8,
   parameter int LETTERS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   output int          mismatches,
   output int          pending_results
);
   import tkst_pkg::*;

   // One stored record of the ranking.
   typedef struct packed {
      logic [SCORE_W-1:0]                 score;
      logic [BYTE_W-1:0]                  player;
      logic [BYTE_W-1:0]                  mode;
      logic [MAX_LETTERS-1:0][BYTE_W-1:0] initials;
   } rank_record_type;

   // Fields of one response beat.
   typedef struct packed {
      logic               accepted;
      logic [SLOT_W-1:0]  slot;
      logic [SCORE_W-1:0] score;
      logic [BYTE_W-1:0]  player;
      logic [BYTE_W-1:0]  mode;
      logic [BYTE_W-1:0]  first_initial;
      logic [BYTE_W-1:0]  second_initial;
      logic [BYTE_W-1:0]  third_initial;
   } rank_response_type;

   rank_record_type   ranks [ENTRIES];
   rank_response_type responses_due [$];
   int                error_count = 0;

   // Applies one request beat to the ranking and returns the response it yields.
   function automatic rank_response_type apply_request(input tkst_op_type op,
                                                       input logic [63:0] data);
      rank_response_type  res;
      rank_record_type    rec;
      int                 pos;
      logic [SCORE_W-1:0] score;
      logic [SLOT_W-1:0]  idx;
      logic [BYTE_W-1:0]  offered [IN_LETTERS];
      res        = '0;
      rec        = '0;
      pos        = -1;
      score      = data[15:0];
      idx        = data[58:56];
      offered[0] = data[39:32];
      offered[1] = data[47:40];
      offered[2] = data[55:48];
      if (op == OP_OFFER) begin
         // The first slot holding a strictly lower score takes the offer.
         for (int i = 0; i < ENTRIES; i++) begin
            if (pos < 0 && score > ranks[i].score) begin
               pos = i;
            end
         end
         if (pos >= 0) begin
            for (int i = ENTRIES - 1; i > pos; i--) begin
               ranks[i] = ranks[i-1];
            end
            rec.score  = score;
            rec.player = data[23:16];
            rec.mode   = data[31:24];
            // Anything that is not an upper-case letter becomes a space.
            for (int k = 0; k < LETTERS && k < IN_LETTERS; k++) begin
               rec.initials[k] = (offered[k] >= CHAR_A && offered[k] <= CHAR_Z) ?
                                 offered[k] : CHAR_SPACE;
            end
            ranks[pos]   = rec;
            res.accepted = 1'b1;
            res.slot     = SLOT_W'(pos);
         end
      end else begin
         res.slot = idx;
         if (idx < ENTRIES) begin
            rec                = ranks[idx];
            res.score          = rec.score;
            res.player         = rec.player;
            res.mode           = rec.mode;
            res.first_initial  = (LETTERS > 0) ? rec.initials[0] : '0;
            res.second_initial = (LETTERS > 1) ? rec.initials[1] : '0;
            res.third_initial  = (LETTERS > 2) ? rec.initials[2] : '0;
         end
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Responses are checked before the request beat of the same edge is
   // predicted, since a response always belongs to an earlier request.
   always @(posedge clock) begin
      rank_response_type want;
      rank_response_type got;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            ranks[i] = '0;
         end
         responses_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.accepted       = rsp_tuser[0];
            got.slot           = rsp_tdata[2:0];
            got.score          = rsp_tdata[18:3];
            got.player         = rsp_tdata[26:19];
            got.mode           = rsp_tdata[34:27];
            got.first_initial  = rsp_tdata[42:35];
            got.second_initial = rsp_tdata[50:43];
            got.third_initial  = rsp_tdata[58:51];
            if (responses_due.size() == 0) begin
               $display("%0t: response beat with none expected, got %0h", $time, got);
               error_count++;
            end else begin
               want = responses_due.pop_front();
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("slot", want.slot, got.slot);
               compare_field("entry_score", want.score, got.score);
               compare_field("entry_player", want.player, got.player);
               compare_field("entry_mode", want.mode, got.mode);
               compare_field("entry_letter_first", want.first_initial,
                             got.first_initial);
               compare_field("entry_letter_second", want.second_initial,
                             got.second_initial);
               compare_field("entry_letter_third", want.third_initial,
                             got.third_initial);
            end
         end
         if (req_tvalid && req_tready) begin
            responses_due.push_back(apply_request(tkst_op_type'(req_tuser[0]), req_tdata));
         end
      end
      mismatches      <= error_count;
      pending_results <= responses_due.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import tkst_pkg::*;

   localparam int RANDOM_ITEMS  = 1400;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int RECENT_SCORES = 16;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   int mismatch_count;
   int results_due;
   int quiet_cycles = 0;
   bit idle_on      = 1'b1;
   bit hold_off_req = 1'b0;
   logic [15:0] recent_scores [$];

   always #1 clock = ~clock;

   top_k_sorted_insert_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   top_k_table_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatches      (mismatch_count),
      .pending_results (results_due)
   );

   // Offers one request beat, after a random gap, and waits until it is taken.
   task automatic send_beat(input tkst_op_type op, input logic [15:0] score,
                            input logic [7:0] player, input logic [7:0] mode,
                            input logic [7:0] l1, input logic [7:0] l2,
                            input logic [7:0] l3, input logic [2:0] idx);
      while (idle_on && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, idx, l3, l2, l1, mode, player, score};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer(input logic [15:0] score, input logic [7:0] l1,
                        input logic [7:0] l2, input logic [7:0] l3);
      send_beat(OP_OFFER, score, 8'($urandom), 8'($urandom), l1, l2, l3,
                3'($urandom));
   endtask

   task automatic read_slot(input logic [2:0] idx);
      send_beat(OP_READ, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), idx);
   endtask

   // Lowers valid and waits until every response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Mostly letters, sometimes any byte at all.
   function automatic logic [7:0] initial_byte();
      if ($urandom_range(99) < 60) begin
         return 8'($urandom_range(CHAR_A, CHAR_Z));
      end
      return 8'($urandom);
   endfunction

   // Score mix: uniform, ties with recent offers, a rising ramp so the table
   // keeps taking entries late in the run, and the extremes.
   function automatic logic [15:0] pick_score(input int n);
      int sel;
      int ramp;
      logic [15:0] s;
      sel = $urandom_range(99);
      if (sel < 30 || (sel < 55 && recent_scores.size() == 0)) begin
         s = 16'($urandom);
      end else if (sel < 55) begin
         s = recent_scores[$urandom_range(recent_scores.size() - 1)];
         if ($urandom_range(1) == 1) begin
            s = s + 16'($urandom_range(2)) - 16'd1;
         end
      end else if (sel < 90) begin
         ramp = n * 46 + $urandom_range(400);
         s = (ramp > 65535) ? 16'hFFFF : 16'(ramp);
      end else begin
         case ($urandom_range(3))
            0: s = 16'h0000;
            1: s = 16'h0001;
            2: s = 16'hFFFE;
            default: s = 16'hFFFF;
         endcase
      end
      return s;
   endfunction

   // Response side: random stalls, or one long hold-off when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= !(idle_on && $urandom_range(99) < 35);
      end
   end

   // Ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("top_k_sorted_insert_table: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] s;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty table: reads return zero and a zero score cannot enter.
      read_slot(3'd0);
      read_slot(3'd7);
      offer(16'h0000, CHAR_A, CHAR_A, CHAR_A);
      // Top score with initials at and just past the letter bounds.
      offer(16'hFFFF, CHAR_A, CHAR_Z, 8'h40);
      // A tie lands behind the existing record.
      offer(16'hFFFF, 8'h5B, 8'h00, 8'hFF);
      offer(16'd1, 8'h61, 8'h7A, 8'h60);
      offer(16'd500, CHAR_SPACE, 8'h4D, 8'h80);
      offer(16'd300, 8'h51, 8'h52, 8'h53);
      offer(16'd700, 8'h7F, 8'h41, 8'h5A);
      offer(16'd2, 8'h01, 8'h02, 8'h03);
      offer(16'd1000, 8'h4B, 8'h4C, 8'h4E);
      // Table is full now; the lowest record drops out.
      offer(16'd400, 8'h54, 8'h55, 8'h56);
      // Equal to and below the last record are rejected; just above enters.
      offer(16'd2, CHAR_Z, CHAR_Z, CHAR_Z);
      offer(16'd1, CHAR_Z, CHAR_Z, CHAR_Z);
      offer(16'd3, 8'h47, 8'h48, 8'h49);
      for (int i = 0; i < 8; i++) begin
         read_slot(3'(i));
      end

      // Random part.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 1000 && n < 1200);
         if (n == 500) begin
            hold_off_req = 1'b1;
         end
         if (n == 800) begin
            drain_responses();
         end
         if ($urandom_range(99) < 25) begin
            read_slot(3'($urandom));
         end else begin
            s = pick_score(n);
            recent_scores.push_back(s);
            if (recent_scores.size() > RECENT_SCORES) begin
               void'(recent_scores.pop_front());
            end
            offer(s, initial_byte(), initial_byte(), initial_byte());
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("top_k_sorted_insert_table: match");
      end else begin
         $display("top_k_sorted_insert_table: mismatch");
      end
      $finish;
   end

endmodule
